FILE: design/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bicubic image resizer.
// ----------------------------------------------------------------------------
package bir_pkg;

  // default pixel store geometry
  localparam int unsigned DEFAULT_MAX_SRC_W = 256;
  localparam int unsigned DEFAULT_MAX_SRC_H = 256;

  // unsigned Q.16 ratio width: a 9-bit size shifted by 16
  localparam int unsigned RATIO_W = 25;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_TGT_W = 2'd2,
    CFG_TGT_H = 2'd3
  } cfg_idx_e;

  // input word mode
  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_COMPUTE = 1'b1
  } mode_e;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP0,
    ST_MAP1,
    ST_MAP2,
    ST_KERN,
    ST_TAPS,
    ST_DIVI,
    ST_DIV,
    ST_DONE
  } back_state_e;

  // effective image sizes
  typedef struct packed {
    logic [8:0]  src_w;
    logic [8:0]  src_h;
    logic [12:0] tgt_w;
    logic [12:0] tgt_h;
  } bir_size_t;

  // word passed from front to back
  typedef struct packed {
    logic        is_load;
    logic [11:0] col;
    logic [11:0] row;
    logic [23:0] pix;
  } bir_word_t;

endpackage

FILE: design/bir_ram.sv
// ----------------------------------------------------------------------------
// bir_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

FILE: design/bir_queue.sv
// ----------------------------------------------------------------------------
// bir_queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module bir_queue
  import bir_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  bir_word_t push_word_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output bir_word_t pop_word_o
);

  bir_word_t  mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_word_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_d    = push ? ~wr_q : wr_q;
    rd_d    = pop ? ~rd_q : rd_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue fill count out of range");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + {1'b0, $past(push)} - {1'b0, $past(pop)})
    else $error("queue fill count does not track push and pop");
`endif

endmodule

FILE: design/bir_front.sv
// ----------------------------------------------------------------------------
// bir_front
// Accepts input words, drops loads outside the source image, queues the rest.
// ----------------------------------------------------------------------------
module bir_front
  import bir_pkg::*;
(
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,
  input  bir_size_t   size_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output bir_word_t   push_word_o
);

  logic is_load;
  logic in_range;
  logic keep;

  // classify the word
  always_comb begin
    is_load  = (mode_i == MODE_LOAD);
    in_range = (col_i < {3'd0, size_i.src_w}) && (row_i < {3'd0, size_i.src_h});
    keep     = !is_load || in_range;
  end

  assign in_ready_o           = push_ready_i;
  assign push_valid_o         = in_valid_i && keep;
  assign push_word_o.is_load  = is_load;
  assign push_word_o.col      = col_i;
  assign push_word_o.row      = row_i;
  assign push_word_o.pix      = {red_in_i, green_in_i, blue_in_i};

endmodule

FILE: design/bir_ratio.sv
// ----------------------------------------------------------------------------
// bir_ratio
// Restoring dividers for the horizontal and vertical scale ratios.
// ----------------------------------------------------------------------------
module bir_ratio
  import bir_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_i,
  input  bir_size_t          size_i,
  output logic [RATIO_W-1:0] ratio_x_o,
  output logic [RATIO_W-1:0] ratio_y_o,
  output logic               ready_o
);

  logic [RATIO_W-1:0] num_q [2], num_d [2];
  logic [12:0]        den_q [2], den_d [2];
  logic [12:0]        rem_q [2], rem_d [2];
  logic [RATIO_W-1:0] quo_q [2], quo_d [2];
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               pend_q, pend_d;
  logic               start;
  logic [13:0]        trial;

  assign start     = pend_q && !busy_q;
  assign ready_o   = !pend_q && !busy_q;
  assign ratio_x_o = quo_q[0];
  assign ratio_y_o = quo_q[1];

  // one quotient bit per cycle in each lane
  always_comb begin
    pend_d = cfg_wr_i || (pend_q && !start);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    trial  = '0;
    for (int i = 0; i < 2; i++) begin
      num_d[i] = num_q[i];
      den_d[i] = den_q[i];
      rem_d[i] = rem_q[i];
      quo_d[i] = quo_q[i];
    end
    if (start) begin
      num_d[0] = {size_i.src_w, 16'd0};
      num_d[1] = {size_i.src_h, 16'd0};
      den_d[0] = size_i.tgt_w;
      den_d[1] = size_i.tgt_h;
      rem_d[0] = '0;
      rem_d[1] = '0;
      busy_d   = 1'b1;
      cnt_d    = '0;
    end else if (busy_q) begin
      for (int i = 0; i < 2; i++) begin
        trial    = {rem_q[i], num_q[i][RATIO_W-1]};
        num_d[i] = {num_q[i][RATIO_W-2:0], 1'b0};
        if (trial >= {1'b0, den_q[i]}) begin
          rem_d[i] = 13'(trial - {1'b0, den_q[i]});
          quo_d[i] = {quo_q[i][RATIO_W-2:0], 1'b1};
        end else begin
          rem_d[i] = trial[12:0];
          quo_d[i] = {quo_q[i][RATIO_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(RATIO_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 2; i++) begin
      num_q[i] <= num_d[i];
      den_q[i] <= den_d[i];
      rem_q[i] <= rem_d[i];
      quo_q[i] <= quo_d[i];
    end
  end

endmodule

FILE: design/bir_kernel.sv
// ----------------------------------------------------------------------------
// bir_kernel
// Four-stage pipeline evaluating the cubic kernel (a = -0.75) in Q2.14.
// ----------------------------------------------------------------------------
module bir_kernel
  import bir_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [17:0]        in_d_i,
  input  logic [2:0]         in_tag_i,
  output logic               out_valid_o,
  output logic [2:0]         out_tag_o,
  output logic signed [15:0] out_w_o
);

  localparam logic signed [21:0] B_NEAR = 22'sd589824;
  localparam logic signed [21:0] B_FAR  = 22'sd983040;
  localparam logic signed [41:0] C_FAR  = 42'sd103079215104;
  localparam logic signed [60:0] D_NEAR = 61'sd1125899906842624;
  localparam logic signed [60:0] D_FAR  = 61'sd3377699720527872;
  localparam logic signed [60:0] HALF   = 61'sd34359738368;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [2:0]         t1_q, t2_q, t3_q, t4_q;
  logic [17:0]        d1_q, d2_q;
  logic               far1_q, far2_q;
  logic               z1_q, z2_q, z3_q;
  logic signed [21:0] s1_q, s1_d;
  logic signed [41:0] s2_q, s2_d, p2;
  logic signed [60:0] s3_q, s3_d, p3, rnd;
  logic signed [15:0] w4_q, w4_d;
  logic signed [21:0] d22;
  logic               far, zero;

  // horner steps of the two kernel branches
  always_comb begin
    d22  = $signed({4'd0, in_d_i});
    far  = in_d_i > 18'd65536;
    zero = in_d_i >= 18'd131072;
    s1_d = far ? (B_FAR - 22'sd3 * d22) : (22'sd5 * d22 - B_NEAR);
    p2   = s1_q * $signed({1'b0, d1_q});
    s2_d = p2 - (far1_q ? C_FAR : 42'sd0);
    p3   = s2_q * $signed({1'b0, d2_q});
    s3_d = p3 + (far2_q ? D_FAR : D_NEAR);
    rnd  = s3_q + HALF;
    w4_d = z3_q ? 16'sd0 : rnd[51:36];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    t1_q   <= in_tag_i;
    d1_q   <= in_d_i;
    far1_q <= far;
    z1_q   <= zero;
    s1_q   <= s1_d;
    t2_q   <= t1_q;
    d2_q   <= d1_q;
    far2_q <= far1_q;
    z2_q   <= z1_q;
    s2_q   <= s2_d;
    t3_q   <= t2_q;
    z3_q   <= z2_q;
    s3_q   <= s3_d;
    t4_q   <= t3_q;
    w4_q   <= w4_d;
  end

  assign out_valid_o = v4_q;
  assign out_tag_o   = t4_q;
  assign out_w_o     = w4_q;

endmodule

FILE: design/bir_back.sv
// ----------------------------------------------------------------------------
// bir_back
// Executes queued words: stores loads, sequences the 4x4 interpolation.
// ----------------------------------------------------------------------------
module bir_back
  import bir_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_WIDTH  = DEFAULT_MAX_SRC_W,
  parameter int unsigned MAX_SOURCE_HEIGHT = DEFAULT_MAX_SRC_H
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  bir_word_t          pop_word_i,
  input  bir_size_t          size_i,
  input  logic [RATIO_W-1:0] ratio_x_i,
  input  logic [RATIO_W-1:0] ratio_y_i,
  input  logic               ratio_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         blue_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         red_out_o
);

  localparam int unsigned XW    = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_SOURCE_HEIGHT);
  localparam int unsigned DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  // offset, saturate and bias a mapped position
  function automatic logic [29:0] map_pb(input logic [36:0] prod,
                                         input logic [RATIO_W-1:0] ratio);
    logic signed [38:0] pos;
    logic signed [38:0] sat;
    pos = $signed({2'b00, prod}) + $signed({15'd0, ratio[RATIO_W-1:1]}) - 39'sd32768;
    sat = pos;
    if (pos > 39'sd536870911) begin
      sat = 39'sd536870911;
    end else if (pos < -39'sd536870912) begin
      sat = -39'sd536870912;
    end
    sat = sat + 39'sd536870912;
    return sat[29:0];
  endfunction

  // edge clamp of one tap index
  function automatic logic [8:0] clamp_tap(input logic signed [13:0] base,
                                           input logic [1:0] k,
                                           input logic [8:0] sz);
    logic signed [14:0] t;
    t = 15'(base) + $signed({13'd0, k}) - 15'sd1;
    if (t < 15'sd0) begin
      return 9'd0;
    end else if (t >= $signed({6'd0, sz})) begin
      return sz - 9'd1;
    end else begin
      return t[8:0];
    end
  endfunction

  back_state_e        state_q, state_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [23:0]        ram_rdata;
  logic               out_load;
  logic               issue;

  logic [11:0]        col_q, row_q;
  logic [36:0]        prodx_q, prody_q;
  logic [29:0]        pbx, pby;
  logic signed [13:0] ix_q, iy_q;
  logic [15:0]        u_q, v_q;
  logic [XW-1:0]      px_q [4];
  logic [YW-1:0]      py_q [4];

  logic               k_valid;
  logic [17:0]        k_d;
  logic [15:0]        k_frac;
  logic               k_out_valid;
  logic [2:0]         k_out_tag;
  logic signed [15:0] k_out_w;
  logic signed [15:0] wx_q [4];
  logic signed [15:0] wy_q [4];

  logic               bv_q, cv_q;
  logic signed [31:0] wprod_q, wprod2_q;
  logic signed [40:0] prod_q [3];
  logic signed [39:0] acc_q [3];
  logic signed [31:0] tw_q;

  logic [41:0]        rem_q [3];
  logic [41:0]        dsh_q;
  logic [7:0]         quo_q [3];
  logic               run_q [3];
  logic [7:0]         res_q [3];
  logic               out_valid_q;
  logic [7:0]         out_q [3];

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pop_ready_o = 1'b0;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          if (pop_word_i.is_load) begin
            pop_ready_o = 1'b1;
            ram_we      = 1'b1;
          end else if (ratio_ok_i) begin
            pop_ready_o = 1'b1;
            state_d     = ST_MAP0;
          end
        end
      end
      ST_MAP0: state_d = ST_MAP1;
      ST_MAP1: state_d = ST_MAP2;
      ST_MAP2: begin
        state_d = ST_KERN;
        cnt_d   = '0;
      end
      ST_KERN: begin
        if (cnt_q < 5'd8) begin
          cnt_d = cnt_q + 5'd1;
        end
        if (k_out_valid && k_out_tag == 3'd7) begin
          state_d = ST_TAPS;
          cnt_d   = '0;
        end
      end
      ST_TAPS: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd17) begin
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd7) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      bv_q        <= 1'b0;
      cv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bv_q        <= issue;
      cv_q        <= bv_q;
      out_valid_q <= out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  // pixel store port: loads write, taps read
  assign issue = (state_q == ST_TAPS) && (cnt_q < 5'd16);
  always_comb begin
    if (state_q == ST_IDLE) begin
      ram_addr = AW'(AW'(pop_word_i.row[YW-1:0]) * AW'(MAX_SOURCE_WIDTH))
               + AW'(pop_word_i.col[XW-1:0]);
    end else begin
      ram_addr = AW'(AW'(py_q[cnt_q[3:2]]) * AW'(MAX_SOURCE_WIDTH))
               + AW'(px_q[cnt_q[1:0]]);
    end
  end

  bir_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pop_word_i.pix),
    .rdata_o (ram_rdata)
  );

  // kernel feed: x distances then y distances
  always_comb begin
    k_valid = (state_q == ST_KERN) && (cnt_q < 5'd8);
    k_frac  = cnt_q[2] ? v_q : u_q;
    unique case (cnt_q[1:0])
      2'd0:    k_d = {2'b00, k_frac} + 18'd65536;
      2'd1:    k_d = {2'b00, k_frac};
      2'd2:    k_d = 18'd65536 - {2'b00, k_frac};
      default: k_d = 18'd131072 - {2'b00, k_frac};
    endcase
  end

  bir_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (k_valid),
    .in_d_i      (k_d),
    .in_tag_i    (cnt_q[2:0]),
    .out_valid_o (k_out_valid),
    .out_tag_o   (k_out_tag),
    .out_w_o     (k_out_w)
  );

  assign pbx = map_pb(prodx_q, ratio_x_i);
  assign pby = map_pb(prody_q, ratio_y_i);

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_ready_o) begin
      col_q <= pop_word_i.col;
      row_q <= pop_word_i.row;
    end
    if (state_q == ST_MAP0) begin
      prodx_q <= 37'(col_q) * 37'(ratio_x_i);
      prody_q <= 37'(row_q) * 37'(ratio_y_i);
    end
    if (state_q == ST_MAP1) begin
      ix_q <= $signed({~pbx[29], pbx[28:16]});
      iy_q <= $signed({~pby[29], pby[28:16]});
      u_q  <= pbx[15:0];
      v_q  <= pby[15:0];
    end
    if (state_q == ST_MAP2) begin
      for (int k = 0; k < 4; k++) begin
        px_q[k] <= XW'(clamp_tap(ix_q, 2'(k), size_i.src_w));
        py_q[k] <= YW'(clamp_tap(iy_q, 2'(k), size_i.src_h));
      end
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
      tw_q <= '0;
    end
    // collect weights
    if (k_out_valid) begin
      if (k_out_tag[2]) begin
        wy_q[k_out_tag[1:0]] <= k_out_w;
      end else begin
        wx_q[k_out_tag[1:0]] <= k_out_w;
      end
    end
    // tap pipeline: weight product, channel products, accumulate
    wprod_q  <= wx_q[cnt_q[1:0]] * wy_q[cnt_q[3:2]];
    wprod2_q <= wprod_q;
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= $signed({1'b0, ram_rdata[8*c +: 8]}) * wprod_q;
    end
    if (cv_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q[c] + 40'(prod_q[c]);
      end
      tw_q <= tw_q + wprod2_q;
    end
    // final division setup
    if (state_q == ST_DIVI) begin
      dsh_q <= 42'({tw_q, 1'b0, 7'd0});
      for (int c = 0; c < 3; c++) begin
        quo_q[c] <= '0;
        run_q[c] <= 1'b0;
        rem_q[c] <= 42'($signed({acc_q[c], 1'b0})) + 42'(tw_q);
        if (acc_q[c] <= 40'sd0) begin
          res_q[c] <= 8'd0;
        end else if (tw_q > 32'sd0) begin
          if ((42'($signed({acc_q[c], 1'b0})) + 42'(tw_q)) >= 42'({tw_q, 1'b0, 8'd0})) begin
            res_q[c] <= 8'd255;
          end else begin
            run_q[c] <= 1'b1;
          end
        end else begin
          res_q[c] <= ((acc_q[c] + 40'sd134217728) >>> 28) > 40'sd255
                    ? 8'd255 : 8'((acc_q[c] + 40'sd134217728) >>> 28);
        end
      end
    end
    // restoring division, one quotient bit per cycle
    if (state_q == ST_DIV) begin
      dsh_q <= dsh_q >> 1;
      for (int c = 0; c < 3; c++) begin
        if (rem_q[c] >= dsh_q) begin
          rem_q[c] <= rem_q[c] - dsh_q;
          quo_q[c] <= {quo_q[c][6:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][6:0], 1'b0};
        end
      end
    end
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        out_q[c] <= run_q[c] ? quo_q[c] : res_q[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = out_q[0];
  assign green_out_o = out_q[1];
  assign red_out_o   = out_q[2];

`ifndef SYNTH
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("pixel store written outside idle");
  a_taps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAPS) |-> (cnt_q <= 5'd17))
    else $error("tap counter overrun");
  a_kern_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_out_valid |-> (state_q == ST_KERN))
    else $error("kernel weight outside collection window");
  a_ratio_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAP0) |-> $past(ratio_ok_i))
    else $error("compute started before ratios were ready");
`endif

endmodule

FILE: design/bicubic_image_resizer.sv
// ----------------------------------------------------------------------------
// bicubic_image_resizer
// Bicubic resizer of an RGB image held in an on-chip pixel store.
// ----------------------------------------------------------------------------
// A load word writes one pixel in the back end; a compute word occupies the
// back end from when it leaves the queue until its result is loaded into the
// output register. The time is set by the sixteen reads of the single-port
// pixel store, the eight kernel evaluations through a four-stage pipeline,
// and an eight-step divider for the weight normalization. Words are taken one
// at a time; a two-entry queue lets input continue while the back end works,
// and a finished pixel waits in an output register without stopping the next
// word. After reset and after any configuration write the scale ratios are
// recomputed (again when a write lands during a recompute), during which
// compute words wait.
module bicubic_image_resizer
  import bir_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_WIDTH  = DEFAULT_MAX_SRC_W,
  parameter int unsigned MAX_SOURCE_HEIGHT = DEFAULT_MAX_SRC_H
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  red_out_o
);

  logic [8:0]         src_w_q, src_h_q;
  logic [12:0]        tgt_w_q, tgt_h_q;
  logic               cfg_wr;
  bir_size_t          size;
  logic               push_valid, push_ready;
  bir_word_t          push_word;
  logic               pop_valid, pop_ready;
  bir_word_t          pop_word;
  logic [RATIO_W-1:0] ratio_x, ratio_y;
  logic               ratio_ok;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      tgt_w_q <= 13'd256;
      tgt_h_q <= 13'd256;
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_W: src_w_q <= cfg_data_i[8:0];
        CFG_SRC_H: src_h_q <= cfg_data_i[8:0];
        CFG_TGT_W: tgt_w_q <= cfg_data_i;
        CFG_TGT_H: tgt_h_q <= cfg_data_i;
        default:   src_w_q <= src_w_q;
      endcase
    end
  end

  // effective sizes: zero reads as one, source capped at the store size
  always_comb begin
    size.src_w = (src_w_q == 9'd0) ? 9'd1
               : ({4'd0, src_w_q} > 13'(MAX_SOURCE_WIDTH)) ? 9'(MAX_SOURCE_WIDTH) : src_w_q;
    size.src_h = (src_h_q == 9'd0) ? 9'd1
               : ({4'd0, src_h_q} > 13'(MAX_SOURCE_HEIGHT)) ? 9'(MAX_SOURCE_HEIGHT) : src_h_q;
    size.tgt_w = (tgt_w_q == 13'd0) ? 13'd1 : tgt_w_q;
    size.tgt_h = (tgt_h_q == 13'd0) ? 13'd1 : tgt_h_q;
  end

  bir_ratio u_ratio (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_wr_i  (cfg_wr),
    .size_i    (size),
    .ratio_x_o (ratio_x),
    .ratio_y_o (ratio_y),
    .ready_o   (ratio_ok)
  );

  bir_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .blue_in_i    (blue_in_i),
    .green_in_i   (green_in_i),
    .red_in_i     (red_in_i),
    .size_i       (size),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_word_o  (push_word)
  );

  bir_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_word_o   (pop_word)
  );

  bir_back #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_word_i  (pop_word),
    .size_i      (size),
    .ratio_x_i   (ratio_x),
    .ratio_y_i   (ratio_y),
    .ratio_ok_i  (ratio_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o)
  );

endmodule

FILE: tb/sv/bicubic_image_resizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bicubic_image_resizer_test
// Loads small source images, resizes them through a range of size settings
// and checks every output pixel against a fixed-point bicubic predictor.
// ----------------------------------------------------------------------------
module bicubic_image_resizer_test;
  import bir_pkg::*;

  localparam int unsigned STORE_W   = DEFAULT_MAX_SRC_W;
  localparam int unsigned STORE_H   = DEFAULT_MAX_SRC_H;
  localparam int          WDOG_MAX  = 3000;
  localparam int          DRAIN_CYC = 80;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // bicubic predictor with its own pixel store and size registers
  class resize_scoreboard;
    logic [23:0] pix_mem [STORE_W*STORE_H];
    int unsigned src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    rgb_t        pending_pix[$];
    int          errors;

    function new();
      src_w_reg = 256;
      src_h_reg = 256;
      tgt_w_reg = 256;
      tgt_h_reg = 256;
      errors    = 0;
    endfunction

    function void report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endfunction

    function int unsigned eff_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [12:0] val);
      case (idx)
        CFG_SRC_W: src_w_reg = val[8:0];
        CFG_SRC_H: src_h_reg = val[8:0];
        CFG_TGT_W: tgt_w_reg = val;
        CFG_TGT_H: tgt_h_reg = val;
      endcase
    endfunction

    // keys kernel, a = -0.75, q16 distance to q14 weight
    function longint keys_weight(longint d);
      longint d2, d3, v;
      d2 = d * d;
      d3 = d2 * d;
      if (d <= 65536)
        v = 5 * d3 - 9 * (d2 * 65536) + 4 * (longint'(1) << 48);
      else if (d < 131072)
        v = -3 * d3 + 15 * (d2 * 65536) - 24 * (d * (longint'(1) << 32))
            + 12 * (longint'(1) << 48);
      else
        return 0;
      return (v + (longint'(1) << 35)) >>> 36;
    endfunction

    // output coordinate to source index and q16 fraction
    function void map_axis(int unsigned c, int unsigned oldsz, int unsigned newsz,
                           output int idx, output longint frac);
      longint ratio, pos;
      ratio = (longint'(oldsz) << 16) / longint'(newsz);
      if (ratio > 64'h0FFF_FFFF) ratio = 64'h0FFF_FFFF;
      pos = longint'(c) * ratio + (ratio >> 1) - 32768;
      if (pos > (longint'(1) << 29) - 1) pos = (longint'(1) << 29) - 1;
      if (pos < -(longint'(1) << 29)) pos = -(longint'(1) << 29);
      idx  = int'(pos >>> 16);
      frac = pos & 64'hFFFF;
    endfunction

    function logic [7:0] finish_chan(longint acc, longint tw);
      longint q;
      if (acc <= 0) return 8'd0;
      if (tw > 0) q = (2 * acc + tw) / (2 * tw);
      else q = (acc + (longint'(1) << 27)) / (longint'(1) << 28);
      if (q > 255) q = 255;
      return q[7:0];
    endfunction

    function int clamp_idx(int v, int unsigned sz);
      if (v < 0) return 0;
      if (v >= int'(sz)) return int'(sz) - 1;
      return v;
    endfunction

    // note an accepted input word
    function void note_word(mode_e mode, logic [11:0] col, logic [11:0] row,
                            logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned sw, sh, tw_sz, th_sz;
      int          ix, iy, px, py;
      longint      u, v, w, tw;
      longint      wx[4], wy[4], acc[3];
      logic [23:0] p;
      rgb_t        res;
      sw = eff_size(src_w_reg, STORE_W);
      sh = eff_size(src_h_reg, STORE_H);
      tw_sz = eff_size(tgt_w_reg, 8191);
      th_sz = eff_size(tgt_h_reg, 8191);
      if (mode == MODE_LOAD) begin
        if (col < sw && row < sh) pix_mem[row * STORE_W + col] = {r, g, b};
        return;
      end
      map_axis(col, sw, tw_sz, ix, u);
      map_axis(row, sh, th_sz, iy, v);
      wx[0] = keys_weight(u + 65536);   wy[0] = keys_weight(v + 65536);
      wx[1] = keys_weight(u);           wy[1] = keys_weight(v);
      wx[2] = keys_weight(65536 - u);   wy[2] = keys_weight(65536 - v);
      wx[3] = keys_weight(131072 - u);  wy[3] = keys_weight(131072 - v);
      acc[0] = 0; acc[1] = 0; acc[2] = 0; tw = 0;
      for (int m = 0; m < 4; m++) begin
        py = clamp_idx(iy + m - 1, sh);
        for (int n = 0; n < 4; n++) begin
          px = clamp_idx(ix + n - 1, sw);
          p = pix_mem[py * STORE_W + px];
          w = wx[n] * wy[m];
          acc[0] += longint'(p[7:0]) * w;
          acc[1] += longint'(p[15:8]) * w;
          acc[2] += longint'(p[23:16]) * w;
          tw += w;
        end
      end
      res.blue  = finish_chan(acc[0], tw);
      res.green = finish_chan(acc[1], tw);
      res.red   = finish_chan(acc[2], tw);
      pending_pix.push_back(res);
    endfunction

    // compare a delivered pixel with the oldest prediction
    function void check_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      rgb_t e;
      if (pending_pix.size() == 0) begin
        report($sformatf("unexpected pixel b=%0d g=%0d r=%0d", b, g, r));
        return;
      end
      e = pending_pix.pop_front();
      if (b !== e.blue)  report($sformatf("blue %0d, want %0d", b, e.blue));
      if (g !== e.green) report($sformatf("green %0d, want %0d", g, e.green));
      if (r !== e.red)   report($sformatf("red %0d, want %0d", r, e.red));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [11:0] col_i;
  logic [11:0] row_i;
  logic [7:0]  blue_in_i;
  logic [7:0]  green_in_i;
  logic [7:0]  red_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  blue_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  red_out_o;

  resize_scoreboard sb;
  int          burst_left;
  int          max_gap;
  int          word_count;
  int          idle_cycles;
  int          stall_phase = 0;
  int unsigned rdy_mode = 0;

  bicubic_image_resizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .blue_in_i   (blue_in_i),
    .green_in_i  (green_in_i),
    .red_in_i    (red_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver stall pattern, result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_pixel(blue_out_o, green_out_o, red_out_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
    stall_phase++;
    if (stall_phase >= 60) begin
      stall_phase = 0;
      rdy_mode = $urandom_range(0, 3);
    end
    case (rdy_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (stall_phase >= 40);
    endcase
  end

  // one configuration write, valid left high for the caller to drop
  task automatic write_reg(cfg_idx_e idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
    write_reg(CFG_SRC_W, sw[12:0]);
    write_reg(CFG_SRC_H, sh[12:0]);
    write_reg(CFG_TGT_W, tw[12:0]);
    write_reg(CFG_TGT_H, th[12:0]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one input word, in bursts with random gaps
  task automatic send_word(mode_e mode, logic [11:0] col, logic [11:0] row,
                           logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    col_i      <= col;
    row_i      <= row;
    blue_in_i  <= b;
    green_in_i <= g;
    red_in_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(mode, col, row, b, g, r);
    burst_left--;
    word_count++;
  endtask

  // drop valid, drain predictions, let trailing loads settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending_pix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // fill the whole effective source image
  task automatic load_image();
    int unsigned sw, sh;
    sw = sb.eff_size(sb.src_w_reg, STORE_W);
    sh = sb.eff_size(sb.src_h_reg, STORE_H);
    for (int y = 0; y < int'(sh); y++)
      for (int x = 0; x < int'(sw); x++)
        send_word(MODE_LOAD, 12'(x), 12'(y), rand_chan(), rand_chan(), rand_chan());
  endtask

  // random mix of computes, reloads and out-of-range loads
  task automatic random_traffic(int n);
    int unsigned sw, sh, tw, th, c, r;
    sw = sb.eff_size(sb.src_w_reg, STORE_W);
    sh = sb.eff_size(sb.src_h_reg, STORE_H);
    tw = sb.eff_size(sb.tgt_w_reg, 8191);
    th = sb.eff_size(sb.tgt_h_reg, 8191);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: send_word(MODE_LOAD, 12'($urandom_range(0, sw - 1)),
                        12'($urandom_range(0, sh - 1)),
                        rand_chan(), rand_chan(), rand_chan());
        2: begin
          c = $urandom_range(0, 4095);
          r = (c >= sw) ? $urandom_range(0, 4095) : $urandom_range(sh, 4095);
          if (sh < 4096 && r >= sh || c >= sw)
            send_word(MODE_LOAD, 12'(c), 12'(r), rand_chan(), rand_chan(), rand_chan());
        end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            c = $urandom_range(0, 4095);
            r = $urandom_range(0, 4095);
          end else begin
            c = $urandom_range(0, (tw > 4096 ? 4096 : tw) - 1);
            r = $urandom_range(0, (th > 4096 ? 4096 : th) - 1);
          end
          send_word(MODE_COMPUTE, 12'(c), 12'(r), 8'($urandom), 8'($urandom),
                    8'($urandom));
        end
      endcase
    end
  endtask

  function automatic int unsigned pick_src(int unsigned other);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return (other <= 2) ? $urandom_range(257, 511) : 1;
      2: return (other <= 2) ? 256 : 1;
      default: return (other > 8) ? 1 : $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int unsigned pick_tgt();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 8191;
      3: return 4096;
      4: return $urandom_range(1, 8191);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned sw, sh;
    sb = new();
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_SRC_W;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    mode_i      <= MODE_LOAD;
    col_i       <= '0;
    row_i       <= '0;
    blue_in_i   <= '0;
    green_in_i  <= '0;
    red_in_i    <= '0;
    burst_left  = 0;
    max_gap     = 3;
    word_count  = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero sizes act as one: single-pixel source, loads outside ignored
    set_sizes(0, 0, 0, 0);
    send_word(MODE_LOAD, 0, 0, 8'hFF, 8'h00, 8'hFF);
    send_word(MODE_LOAD, 12'hFFF, 12'hFFF, 8'h00, 8'hFF, 8'h00);
    send_word(MODE_LOAD, 1, 0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_COMPUTE, 0, 0, 8'hFF, 8'hFF, 8'hFF);
    send_word(MODE_COMPUTE, 12'hFFF, 12'hFFF, 8'h00, 8'h00, 8'h00);
    send_word(MODE_COMPUTE, 12'hFFF, 0, 8'h55, 8'hAA, 8'h55);
    wait_idle();

    // small source with sharp edges, beyond-target computes
    set_sizes(4, 3, 8191, 2);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++)
        send_word(MODE_LOAD, 12'(x), 12'(y), ((x + y) & 1) ? 8'hFF : 8'h00,
                  8'hAA, ((x + y) & 1) ? 8'h00 : 8'hFF);
    send_word(MODE_LOAD, 4, 0, 8'h12, 8'h34, 8'h56);
    send_word(MODE_LOAD, 0, 3, 8'h12, 8'h34, 8'h56);
    send_word(MODE_COMPUTE, 0, 0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_COMPUTE, 12'd4095, 1, 8'h00, 8'h00, 8'h00);
    send_word(MODE_COMPUTE, 12'd2048, 12'd4095, 8'h00, 8'h00, 8'h00);
    send_word(MODE_COMPUTE, 12'd1, 12'd1, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // random phases over many size settings
    while (word_count < 900) begin
      sw = pick_src(0);
      sh = pick_src(sb.eff_size(sw, STORE_W));
      max_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      set_sizes(sw, sh, pick_tgt(), pick_tgt());
      load_image();
      random_traffic($urandom_range(20, 60));
      wait_idle();
    end

    if (sb.pending_pix.size() != 0) sb.report("predicted pixels never delivered");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bir_pkg.sv
design/bir_ram.sv
design/bir_queue.sv
design/bir_front.sv
design/bir_ratio.sv
design/bir_kernel.sv
design/bir_back.sv
design/bicubic_image_resizer.sv
tb/sv/bicubic_image_resizer_test.sv
